FILE: src/isolated_spike_removal_top_macros.svh
// -----------------------------------------------------------------------------
// isolated_spike_removal_top_macros.svh
// Assertion shorthands for the isolated spike removal block. They expect a
// clock named clk and an active-high reset named rst in scope.
// -----------------------------------------------------------------------------
`ifndef ISOLATED_SPIKE_REMOVAL_TOP_MACROS_SVH
`define ISOLATED_SPIKE_REMOVAL_TOP_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define ISR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ISR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/isr_pkg.sv
// -----------------------------------------------------------------------------
// isr_pkg
// Shared types, sizes and helpers for the isolated spike removal block.
// -----------------------------------------------------------------------------
package isr_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int HEIGHT_BITS    = 16;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int WCNT_BITS      = $clog2(MAX_WIDTH + 1);
  localparam int FW_BITS        = 12;
  localparam int FH_BITS        = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Reciprocal of 3 for an exact floor divide of a HEIGHT_BITS value.
  localparam logic [HEIGHT_BITS-1:0] DIV3_MUL =
    HEIGHT_BITS'(((64'd1 << (HEIGHT_BITS + 1)) + 64'd2) / 64'd3);

  typedef logic [HEIGHT_BITS-1:0] height_t;
  typedef logic [COL_BITS-1:0]    col_t;
  typedef logic [WCNT_BITS-1:0]   wcnt_t;
  typedef logic [FH_BITS-1:0]     row_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_SPIKE_LIMIT   = 2'd2,
    REG_FILTER_ENABLE = 2'd3
  } cfg_reg_t;

  // One line-store entry: pending pixel plus its up-neighbour test result.
  typedef struct packed {
    logic    up_ok;
    height_t ground;
    height_t top;
  } store_entry_t;

  function automatic height_t excess_of(input height_t g, input height_t t);
    return (t >= g) ? height_t'(t - g) : '0;
  endfunction

  function automatic height_t div3(input height_t e);
    logic [2*HEIGHT_BITS-1:0] prod;
    prod = {{HEIGHT_BITS{1'b0}}, e} * {{HEIGHT_BITS{1'b0}}, DIV3_MUL};
    return {1'b0, prod[2*HEIGHT_BITS-1:HEIGHT_BITS+1]};
  endfunction

endpackage

FILE: src/isolated_spike_removal_top.sv
// -----------------------------------------------------------------------------
// isolated_spike_removal_top
// Streaming isolated spike removal over a height raster, one pixel per
// transfer in row order, built around a one-row line store.
// -----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------
//  in       | sink      | in_valid / in_stall  | action, ground_height, top_height
//  out      | source    | out_valid / out_stall| corrected_top, was_cleared, frame_end
//  cfg      | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One input transfer per cycle while in_stall is low; a result passes through
//  the stage 1 registers (line-store read), then the decision and the output
//  register. The line store has two read ports and one write port, so the
//  center and right neighbour come out in the same cycle.
//  Reset clears positions, counters and pipeline valids; the line store
//  keeps no reset and its contents are never used before they are written.
//  in_stall rises only while a decision waits behind a held output register.
// -----------------------------------------------------------------------------
`include "isolated_spike_removal_top_macros.svh"

module isolated_spike_removal_top (
  input  logic                                clk,
  input  logic                                rst,
  // pixel channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  isr_pkg::height_t                    ground_height,
  input  isr_pkg::height_t                    top_height,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output isr_pkg::height_t                    corrected_top,
  output logic                                was_cleared,
  output logic                                frame_end,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [isr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [isr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import isr_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective geometry
  // ---------------------------------------------------------------------------
  logic [FW_BITS-1:0] frame_width;
  row_t               frame_height;
  height_t            spike_limit;
  logic               filter_enable;

  wcnt_t eff_w;
  row_t  eff_h;

  // Clamp width into 1..MAX_WIDTH, height into 1..max.
  always_comb begin
    if (frame_width == '0) begin
      eff_w = wcnt_t'(1);
    end else if (WCNT_BITS'(frame_width) > wcnt_t'(MAX_WIDTH)) begin
      eff_w = wcnt_t'(MAX_WIDTH);
    end else begin
      eff_w = WCNT_BITS'(frame_width);
    end
    eff_h = (frame_height == '0) ? row_t'(1) : frame_height;
  end

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Position counters
  // ---------------------------------------------------------------------------
  col_t  in_column;
  row_t  in_row;
  col_t  out_column;
  row_t  out_row;
  wcnt_t pending_count;

  // ---------------------------------------------------------------------------
  // Stage 0: accept, classify, issue line-store reads
  // ---------------------------------------------------------------------------
  logic    take;
  logic    px_live;
  logic    dr_live;
  logic    live;
  logic    emit0;
  col_t    rd_addr;
  col_t    rd_addr_right;
  logic    in_col_wrap;
  logic    out_col_wrap;
  logic    last0;
  height_t e_in;
  height_t h3_in;

  assign take          = in_valid && !in_stall;
  assign px_live       = !action && (in_row < eff_h);
  assign dr_live       = action && (in_row >= eff_h) && (pending_count != '0);
  assign live          = px_live || dr_live;
  // Row 0 pixels only fill the store; every other live item decides one pixel.
  assign emit0         = dr_live || (px_live && (in_row != '0));
  assign rd_addr       = action ? out_column : in_column;
  assign rd_addr_right = rd_addr + col_t'(1);
  assign in_col_wrap   = ({1'b0, in_column} == (eff_w - wcnt_t'(1)));
  assign out_col_wrap  = ({1'b0, out_column} == (eff_w - wcnt_t'(1)));
  assign last0         = (out_row == (eff_h - row_t'(1))) && out_col_wrap;
  assign e_in          = excess_of(ground_height, top_height);
  assign h3_in         = div3(e_in);

  // ---------------------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------------------
  logic         s1_valid;
  logic         s1_emit;
  logic         s1_drain;
  logic         s1_row0;
  logic         s1_has_left;
  logic         s1_has_right;
  logic         s1_last;
  col_t         s1_col;
  height_t      s1_ground;
  height_t      s1_top;
  height_t      s1_e_in;
  height_t      s1_h3_in;

  logic         s1_hold;
  logic         s1_fire;
  logic         s1_we;

  // Line store and its forwarding path.
  store_entry_t row_store [MAX_WIDTH];
  store_entry_t rd_center;
  store_entry_t rd_right;
  store_entry_t fwd_data;
  logic         fwd_center;
  logic         fwd_right;
  store_entry_t wr_entry;

  // Hold stage 1 only while its result cannot move into the output register.
  assign s1_hold  = s1_valid && s1_emit && out_valid && out_stall;
  assign s1_fire  = s1_valid && !s1_hold;
  assign s1_we    = s1_fire && !s1_drain;
  assign in_stall = s1_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= live;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload of stage 1 and the read data; advance on every live transfer.
  always_ff @(posedge clk) begin
    if (take && live) begin
      s1_emit      <= emit0;
      s1_drain     <= action;
      s1_row0      <= px_live && (in_row == '0);
      s1_has_left  <= (rd_addr != '0);
      s1_has_right <= (({1'b0, rd_addr} + wcnt_t'(1)) < eff_w);
      s1_last      <= last0;
      s1_col       <= rd_addr;
      s1_ground    <= ground_height;
      s1_top       <= top_height;
      s1_e_in      <= e_in;
      s1_h3_in     <= h3_in;
      rd_center    <= row_store[rd_addr];
      rd_right     <= row_store[rd_addr_right];
      // The entry written at this edge is newer than what the read returns.
      fwd_center   <= s1_we && (s1_col == rd_addr);
      fwd_right    <= s1_we && (s1_col == rd_addr_right);
      fwd_data     <= wr_entry;
    end
    if (s1_we) begin
      row_store[s1_col] <= wr_entry;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: decide the pending pixel, build the write-back entry
  // ---------------------------------------------------------------------------
  store_entry_t center;
  store_entry_t right;
  height_t      e_c;
  height_t      h3_c;
  height_t      e_r;
  height_t      left_excess;
  height_t      left_next;
  logic         clear;
  logic         up_new;

  assign center = fwd_center ? fwd_data : rd_center;
  assign right  = fwd_right  ? fwd_data : rd_right;
  assign e_c    = excess_of(center.ground, center.top);
  assign h3_c   = div3(e_c);
  assign e_r    = excess_of(right.ground, right.top);

  // Candidate, then drop it if any in-frame neighbour stands too high.
  assign clear = filter_enable && (e_c >= spike_limit) && (h3_c != '0) &&
                 center.up_ok &&
                 !(s1_has_left && (left_excess >= h3_c)) &&
                 !(s1_has_right && (e_r >= h3_c)) &&
                 !(!s1_drain && (s1_e_in >= h3_c));

  assign left_next = clear ? '0 : e_c;
  // Up test of the incoming pixel against the corrected pixel above it.
  assign up_new    = s1_row0 ? 1'b1 : (left_next < s1_h3_in);
  assign wr_entry  = '{up_ok: up_new, ground: s1_ground, top: s1_top};

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      left_excess <= left_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      corrected_top <= clear ? center.ground : center.top;
      was_cleared   <= clear;
      frame_end     <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes and position bookkeeping
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_BITS'(2);
      frame_height  <= row_t'(2);
      spike_limit   <= '1;
      filter_enable <= 1'b0;
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      pending_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          frame_width   <= cfg_data[FW_BITS-1:0];
          in_column     <= '0;
          in_row        <= '0;
          out_column    <= '0;
          out_row       <= '0;
          pending_count <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height  <= cfg_data[FH_BITS-1:0];
          in_column     <= '0;
          in_row        <= '0;
          out_column    <= '0;
          out_row       <= '0;
          pending_count <= '0;
        end
        REG_SPIKE_LIMIT: begin
          spike_limit <= cfg_data[HEIGHT_BITS-1:0];
        end
        REG_FILTER_ENABLE: begin
          filter_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (px_live) begin
        // Advance the input position; decisions track it one row behind.
        if (in_col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + row_t'(1);
        end else begin
          in_column <= in_column + col_t'(1);
        end
        if (in_row == '0) begin
          pending_count <= pending_count + wcnt_t'(1);
        end else if (out_col_wrap) begin
          out_column <= '0;
          out_row    <= out_row + row_t'(1);
        end else begin
          out_column <= out_column + col_t'(1);
        end
      end else if (dr_live) begin
        if (pending_count == wcnt_t'(1)) begin
          // Last pixel flushed: start the next frame.
          in_column     <= '0;
          in_row        <= '0;
          out_column    <= '0;
          out_row       <= '0;
          pending_count <= '0;
        end else begin
          pending_count <= pending_count - wcnt_t'(1);
          if (out_col_wrap) begin
            out_column <= '0;
            out_row    <= out_row + row_t'(1);
          end else begin
            out_column <= out_column + col_t'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ISR_ASSERT_ALWAYS(a_pending_bound, pending_count <= eff_w, "pending count above width")
  `ISR_ASSERT_ALWAYS(a_out_col_bound, {1'b0, out_column} < eff_w, "output column out of frame")
  `ISR_ASSERT_IMPL(a_lockstep, (in_row != '0) && (in_row < eff_h), in_column == out_column, "input and decision columns drifted")
  `ISR_ASSERT_IMPL(a_row0_quiet, in_row == '0, (out_row == '0) && (out_column == '0), "decisions advanced during first row")
  `ISR_ASSERT_NEXT(a_s1_held, s1_hold, s1_valid && $stable(s1_col), "held decision lost")

endmodule
